// ===== src/steering_angle_from_row_centroids_unit_macros.svh =====
// assertion macros shared by the block's modules
`ifndef STEERING_ANGLE_FROM_ROW_CENTROIDS_UNIT_MACROS_SVH
`define STEERING_ANGLE_FROM_ROW_CENTROIDS_UNIT_MACROS_SVH

// same-cycle implication
`define SARC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SARC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sarc_pkg.sv =====
package sarc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int ANGLE_W   = 8;
    localparam int SIZE_W    = 11;
    localparam int MARGIN_W  = 9;
    localparam int POS_W     = 10;
    localparam int SUM_W     = 30;
    localparam int CNT_W     = 20;
    localparam int DIV_W     = CNT_W + 1;
    localparam int MEAN_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MARGIN = 2'd2;

    localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH   = 11'd640;
    localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT  = 11'd480;
    localparam logic [MARGIN_W-1:0] RST_BORDER_MARGIN = 9'd30;

    // angle = (lmean - rmean) * 255 / 60, clamped
    localparam int ANGLE_DIV   = 60;
    localparam int MAG_W       = 18;
    localparam int QMAG_W      = 13;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = QMAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_60 = 14'd8739;
    localparam logic [MAG_W-1:0] SAT_NEG_MAG = MAG_W'(128 * ANGLE_DIV);
    localparam logic [MAG_W-1:0] SAT_POS_MAG = MAG_W'(127 * ANGLE_DIV);
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 8'sd127;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -8'sd128;

    typedef enum logic [2:0] {
        S_RUN,
        S_LOAD_L,
        S_DIV_L,
        S_LOAD_R,
        S_DIV_R,
        S_SCALE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_sel_right;
        logic div_step;
        logic save_left;
        logic scale_en;
        logic frame_clear;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic frame_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/sarc_divider.sv =====
module sarc_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_step,
    input  logic [sarc_pkg::SUM_W-1:0]     i_dividend,
    input  logic [sarc_pkg::DIV_W-1:0]     i_divisor,
    output logic [sarc_pkg::SUM_W-1:0]     o_quotient,
    output logic                           o_last
);
    import sarc_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_divisor;
    logic [DIV_W:0]    trial;
    logic              fits;

    // restoring division, one quotient bit per cycle while i_step is high
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        fits  = trial >= {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_load) begin
            r_step <= '0;
        end else if (i_step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (i_step) begin
            r_rem <= fits ? DIV_W'(trial - {1'b0, r_divisor}) : trial[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = (r_step == STEP_W'(DIV_STEPS - 1));

endmodule

// ===== src/sarc_datapath.sv =====
`include "steering_angle_from_row_centroids_unit_macros.svh"

module sarc_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_write,
    input  logic [sarc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sarc_pkg::SIZE_W-1:0]            i_cfg_data,
    input  logic [sarc_pkg::PIX_W-1:0]             i_pixel,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [sarc_pkg::ANGLE_W-1:0]    o_steer_angle,
    input  sarc_pkg::t_cmd                         i_cmd,
    output sarc_pkg::t_sts                         o_sts
);
    import sarc_pkg::*;

    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    logic [MARGIN_W-1:0] r_margin;

    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [SUM_W-1:0] r_left_sum;
    logic [SUM_W-1:0] r_right_sum;
    logic [CNT_W-1:0] r_left_cnt;
    logic [CNT_W-1:0] r_right_cnt;

    logic [MEAN_W-1:0] r_left_mean;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;

    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_angle;
    logic                      n_out_valid;

    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [SIZE_W-1:0] row_ext;
    logic [SIZE_W-1:0] col_ext;
    logic [SIZE_W-1:0] m_ext;
    logic              in_window;
    logic              is_left;
    logic              row_end;
    logic              frame_last;
    logic              hit;

    logic [SUM_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [SUM_W-1:0] div_quotient;
    logic             div_last;

    logic signed [MEAN_W:0] diff;
    logic [MEAN_W:0]        abs_diff;
    logic [MAG_W-1:0]       mag;
    logic [PROD_W-1:0]      qprod;
    logic [ANGLE_W-1:0]     qmag;
    logic signed [ANGLE_W-1:0] angle;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_FRAME_WIDTH;
            r_height <= RST_FRAME_HEIGHT;
            r_margin <= RST_BORDER_MARGIN;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_height <= i_cfg_data;
                CFG_BORDER_MARGIN: r_margin <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to 1..max
    always_comb begin
        priority if (r_width == '0)                   w_eff = SIZE_W'(1);
        else if (r_width > SIZE_W'(MAX_WIDTH))        w_eff = SIZE_W'(MAX_WIDTH);
        else                                          w_eff = r_width;
        priority if (r_height == '0)                  h_eff = SIZE_W'(1);
        else if (r_height > SIZE_W'(MAX_HEIGHT))      h_eff = SIZE_W'(MAX_HEIGHT);
        else                                          h_eff = r_height;
    end

    always_comb begin
        row_ext    = SIZE_W'(r_row);
        col_ext    = SIZE_W'(r_col);
        m_ext      = SIZE_W'(r_margin);
        in_window  = (row_ext > m_ext) && ((row_ext + m_ext) < h_eff) &&
                     (col_ext > m_ext) && ((col_ext + m_ext) < w_eff);
        is_left    = col_ext <= (w_eff >> 1);
        row_end    = (col_ext + SIZE_W'(1)) >= w_eff;
        frame_last = row_end && ((row_ext + SIZE_W'(1)) >= h_eff);
        hit        = i_cmd.accept && in_window && (i_pixel != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clear) begin
            r_row       <= '0;
            r_col       <= '0;
            r_left_sum  <= '0;
            r_right_sum <= '0;
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
        end else if (i_cmd.accept) begin
            if (hit && is_left) begin
                r_left_cnt <= r_left_cnt + CNT_W'(1);
                r_left_sum <= r_left_sum + SUM_W'(r_row);
            end
            if (hit && !is_left) begin
                r_right_cnt <= r_right_cnt + CNT_W'(1);
                r_right_sum <= r_right_sum + SUM_W'(r_row);
            end
            // position holds on the last beat until the frame clear
            if (row_end) begin
                if (!frame_last) begin
                    r_col <= '0;
                    r_row <= r_row + POS_W'(1);
                end
            end else begin
                r_col <= r_col + POS_W'(1);
            end
        end
    end

    // mean = sum / (count + 1), left then right through one divider
    assign div_dividend = i_cmd.div_sel_right ? r_right_sum : r_left_sum;
    assign div_divisor  = i_cmd.div_sel_right ? DIV_W'(r_right_cnt) + DIV_W'(1)
                                              : DIV_W'(r_left_cnt) + DIV_W'(1);

    sarc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_last     (div_last)
    );

    // means stay below 1024 since every summed row index does
    always_comb begin
        diff     = $signed({1'b0, r_left_mean}) - $signed({1'b0, div_quotient[MEAN_W-1:0]});
        abs_diff = diff[MEAN_W] ? (MEAN_W+1)'(-diff) : (MEAN_W+1)'(diff);
        mag      = (MAG_W'(abs_diff) << 8) - MAG_W'(abs_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_left) begin
            r_left_mean <= div_quotient[MEAN_W-1:0];
        end
        if (i_cmd.scale_en) begin
            r_mag <= mag;
            r_neg <= diff[MEAN_W];
        end
    end

    // divide by 60 via reciprocal, exact below the saturation point
    always_comb begin
        qprod = PROD_W'(r_mag[QMAG_W-1:0]) * PROD_W'(RECIP_60);
        qmag  = qprod[PROD_W-1:RECIP_SHIFT];
        if (r_neg) begin
            angle = (r_mag >= SAT_NEG_MAG) ? ANGLE_MIN : $signed(-qmag);
        end else begin
            angle = (r_mag >= SAT_POS_MAG) ? ANGLE_MAX : $signed(qmag);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_angle <= angle;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_steer_angle = r_out_angle;

    assign o_sts.frame_last = frame_last;
    assign o_sts.div_last   = div_last;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    `SARC_ASSERT_NXT(a_emit_shows_beat, i_clk, i_rst_n, i_cmd.emit, r_out_valid,
        "result beat not presented after emit")
    `SARC_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, i_cmd.frame_clear,
        (r_row == '0) && (r_col == '0) && (r_left_cnt == '0) && (r_right_cnt == '0),
        "frame clear left state behind")
    `SARC_ASSERT_NXT(a_beat_holds, i_clk, i_rst_n, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_out_angle),
        "result beat changed while stalled")

endmodule

// ===== src/sarc_ctrl.sv =====
`include "steering_angle_from_row_centroids_unit_macros.svh"

module sarc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pixel_valid,
    output logic           o_pixel_stall,
    output sarc_pkg::t_cmd o_cmd,
    input  sarc_pkg::t_sts i_sts
);
    import sarc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_pixel_valid && (r_state == S_RUN);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN:    if (accept && i_sts.frame_last) n_state = S_LOAD_L;
            S_LOAD_L: n_state = S_DIV_L;
            S_DIV_L:  if (i_sts.div_last) n_state = S_LOAD_R;
            S_LOAD_R: n_state = S_DIV_R;
            S_DIV_R:  if (i_sts.div_last) n_state = S_SCALE;
            S_SCALE:  n_state = S_EMIT;
            S_EMIT:   if (i_sts.out_free) n_state = S_RUN;
            default:  n_state = S_RUN;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = accept;
        o_pixel_stall = (r_state != S_RUN);
        unique case (r_state)
            S_RUN: ;
            S_LOAD_L: begin
                o_cmd.div_load = 1'b1;
            end
            S_DIV_L: begin
                o_cmd.div_step = 1'b1;
            end
            S_LOAD_R: begin
                // left quotient is still in the divider
                o_cmd.save_left     = 1'b1;
                o_cmd.div_load      = 1'b1;
                o_cmd.div_sel_right = 1'b1;
            end
            S_DIV_R: begin
                o_cmd.div_sel_right = 1'b1;
                o_cmd.div_step      = 1'b1;
            end
            S_SCALE: begin
                o_cmd.scale_en    = 1'b1;
                o_cmd.frame_clear = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    `SARC_ASSERT_NXT(a_frame_end_starts_div, i_clk, i_rst_n,
        accept && i_sts.frame_last, r_state == S_LOAD_L,
        "frame end did not start the mean computation")
    `SARC_ASSERT_NXT(a_div_runs_full, i_clk, i_rst_n,
        (r_state == S_DIV_L) && !i_sts.div_last, r_state == S_DIV_L,
        "left division cut short")
    `SARC_ASSERT_NXT(a_emit_waits, i_clk, i_rst_n,
        (r_state == S_EMIT) && !i_sts.out_free, r_state == S_EMIT,
        "result dropped while output register busy")

endmodule

// ===== src/steering_angle_from_row_centroids_unit.sv =====
// Steering angle from the row centroids of a foreground mask. Pixels come in raster order,
// one beat each, and the block tracks row and column itself; the frame size and border
// margin come from the config port, which is always ready and should be written between
// frames. Within a frame a pixel is taken every cycle. After the last pixel of a frame the
// pixel input stalls while the angle is computed, and while the previous angle still sits
// unread in the output register: the two means sum / (count + 1) go in turn through a
// single restoring divider at one quotient bit per cycle, each after a load state; then
// the scale state scales the difference and the emit state loads the clamped angle into
// the output register. The angle beat then waits there while the next frame streams in.
module steering_angle_from_row_centroids_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_stall,
    input  logic [sarc_pkg::PIX_W-1:0]          i_pixel,
    output logic                                o_steer_valid,
    input  logic                                i_steer_stall,
    output logic signed [sarc_pkg::ANGLE_W-1:0] o_steer_angle,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sarc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sarc_pkg::SIZE_W-1:0]         i_cfg_data
);
    import sarc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sarc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_stall (o_pixel_stall),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    sarc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_pixel),
        .i_out_stall   (i_steer_stall),
        .o_out_valid   (o_steer_valid),
        .o_steer_angle (o_steer_angle),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// ===== tb/steer_angle_checker.sv =====
`timescale 1ns / 1ps

module steer_angle_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pixel_valid,
    input  logic                                i_pixel_stall,
    input  logic [sarc_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_steer_valid,
    input  logic                                i_steer_stall,
    input  logic signed [sarc_pkg::ANGLE_W-1:0] i_steer_angle,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sarc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sarc_pkg::SIZE_W-1:0]         i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_angles_owed
);

    logic [sarc_pkg::SIZE_W-1:0]        width_reg;
    logic [sarc_pkg::SIZE_W-1:0]        height_reg;
    logic [sarc_pkg::MARGIN_W-1:0]      margin_reg;
    int unsigned                        row_pos;
    int unsigned                        col_pos;
    logic [sarc_pkg::SUM_W-1:0]         left_sum;
    logic [sarc_pkg::SUM_W-1:0]         right_sum;
    logic [sarc_pkg::CNT_W-1:0]         left_cnt;
    logic [sarc_pkg::CNT_W-1:0]         right_cnt;
    logic signed [sarc_pkg::ANGLE_W-1:0] owed_angles[$];

    function automatic int unsigned used_size(input logic [sarc_pkg::SIZE_W-1:0] v,
                                              input int unsigned cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic logic signed [sarc_pkg::ANGLE_W-1:0] centroid_angle(
        input logic [sarc_pkg::SUM_W-1:0] lsum, input logic [sarc_pkg::CNT_W-1:0] lcnt,
        input logic [sarc_pkg::SUM_W-1:0] rsum, input logic [sarc_pkg::CNT_W-1:0] rcnt);
        longint lmean;
        longint rmean;
        longint scaled;
        longint ang;
        lmean  = lsum / (lcnt + 21'd1);
        rmean  = rsum / (rcnt + 21'd1);
        scaled = (lmean - rmean) * 255;
        // signed division truncates toward zero
        ang = scaled / 60;
        if (ang < -128) ang = -128;
        if (ang > 127) ang = 127;
        return ang[sarc_pkg::ANGLE_W-1:0];
    endfunction

    task automatic clear_frame();
        row_pos   = 0;
        col_pos   = 0;
        left_sum  = '0;
        right_sum = '0;
        left_cnt  = '0;
        right_cnt = '0;
    endtask

    task automatic take_pixel(input logic [sarc_pkg::PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned m;
        w = used_size(width_reg, sarc_pkg::MAX_WIDTH);
        h = used_size(height_reg, sarc_pkg::MAX_HEIGHT);
        m = margin_reg;
        if (pix != 0 && row_pos > m && row_pos + m < h && col_pos > m && col_pos + m < w) begin
            if (col_pos <= w / 2) begin
                left_cnt = left_cnt + 1'b1;
                left_sum = left_sum + row_pos;
            end else begin
                right_cnt = right_cnt + 1'b1;
                right_sum = right_sum + row_pos;
            end
        end
        if (col_pos + 1 >= w) begin
            if (row_pos + 1 >= h) begin
                owed_angles.push_back(centroid_angle(left_sum, left_cnt, right_sum, right_cnt));
                clear_frame();
            end else begin
                col_pos = 0;
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin
        logic signed [sarc_pkg::ANGLE_W-1:0] want;
        if (!i_rst_n) begin
            width_reg  = sarc_pkg::RST_FRAME_WIDTH;
            height_reg = sarc_pkg::RST_FRAME_HEIGHT;
            margin_reg = sarc_pkg::RST_BORDER_MARGIN;
            clear_frame();
            owed_angles.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sarc_pkg::CFG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                    end
                    sarc_pkg::CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                    end
                    sarc_pkg::CFG_BORDER_MARGIN: begin
                        margin_reg = i_cfg_data[sarc_pkg::MARGIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_pixel_valid && !i_pixel_stall) begin
                take_pixel(i_pixel);
            end
            if (i_steer_valid && !i_steer_stall) begin
                if (owed_angles.size() == 0) begin
                    $display("%0t: steer angle beat with none owed, expected none, got %0d",
                             $time, i_steer_angle);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = owed_angles.pop_front();
                    if (i_steer_angle !== want) begin
                        $display("%0t: steer_angle mismatch, expected %0d, got %0d",
                                 $time, want, i_steer_angle);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
        end
        o_angles_owed = owed_angles.size();
    end

endmodule

// ===== tb/steering_angle_from_row_centroids_unit_test.sv =====
`timescale 1ns / 1ps

module steering_angle_from_row_centroids_unit_test;

    // index with no register behind it
    localparam logic [sarc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int RANDOM_PIXELS = 460;
    localparam int QUIET_AFTER   = 360;

    typedef enum {
        FILL_RANDOM,
        FILL_SOLID,
        FILL_EMPTY,
        FILL_LEFT_LOW,
        FILL_RIGHT_LOW,
        FILL_SKEW_LEFT,
        FILL_SKEW_RIGHT
    } t_fill;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_pixel_valid = 1'b0;
    logic [sarc_pkg::PIX_W-1:0]          i_pixel = '0;
    logic                                i_steer_stall = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [sarc_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [sarc_pkg::SIZE_W-1:0]         i_cfg_data = '0;
    logic                                o_pixel_stall;
    logic                                o_steer_valid;
    logic signed [sarc_pkg::ANGLE_W-1:0] o_steer_angle;
    logic                                o_cfg_ready;
    int                                  mismatch_count;
    int                                  angles_owed;

    int idle_level = 0;
    bit quiet = 1'b0;
    int stall_left = 0;
    int random_fed = 0;
    int cur_w = 1;
    int cur_h = 1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    steering_angle_from_row_centroids_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_stall (o_pixel_stall),
        .i_pixel       (i_pixel),
        .o_steer_valid (o_steer_valid),
        .i_steer_stall (i_steer_stall),
        .o_steer_angle (o_steer_angle),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    steer_angle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .i_pixel_stall (o_pixel_stall),
        .i_pixel       (i_pixel),
        .i_steer_valid (o_steer_valid),
        .i_steer_stall (i_steer_stall),
        .i_steer_angle (o_steer_angle),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatch_count),
        .o_angles_owed (angles_owed)
    );

    // angle receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && !quiet && idle_level != 0 && $urandom_range(0, 15) < idle_level)
            stall_left = $urandom_range(1, 7);
        if (stall_left != 0) begin
            i_steer_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_steer_stall <= 1'b0;
        end
    end

    function automatic logic [sarc_pkg::PIX_W-1:0] pixel_for(input t_fill fill, input int r,
                                                              input int c);
        logic [sarc_pkg::PIX_W-1:0] fg;
        bit left_side;
        bit low_half;
        fg        = 8'($urandom_range(1, 255));
        left_side = (c <= cur_w / 2);
        low_half  = (2 * r >= cur_h);
        case (fill)
            FILL_SOLID:      return 8'hFF;
            FILL_EMPTY:      return 8'h00;
            FILL_LEFT_LOW:   return (c == 1 && r == cur_h - 1) ? fg : 8'h00;
            FILL_RIGHT_LOW:  return (c == cur_w - 1 && r == cur_h - 1) ? fg : 8'h00;
            FILL_SKEW_LEFT:  return (left_side == low_half && $urandom_range(0, 2) != 0) ? fg : 8'h00;
            FILL_SKEW_RIGHT: return (left_side != low_half && $urandom_range(0, 2) != 0) ? fg : 8'h00;
            default:         return ($urandom_range(0, 1) != 0) ? fg : 8'h00;
        endcase
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_SOLID;
            1:       return FILL_EMPTY;
            2:       return FILL_SKEW_LEFT;
            3:       return FILL_SKEW_RIGHT;
            4:       return FILL_LEFT_LOW;
            5:       return FILL_RIGHT_LOW;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // leaves valid high; the caller lowers it once the last write is taken
    task automatic write_reg(input logic [sarc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sarc_pkg::SIZE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [sarc_pkg::SIZE_W-1:0] w,
                             input logic [sarc_pkg::SIZE_W-1:0] h,
                             input logic [sarc_pkg::SIZE_W-1:0] m);
        write_reg(sarc_pkg::CFG_FRAME_WIDTH, w);
        write_reg(sarc_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(sarc_pkg::CFG_BORDER_MARGIN, m);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNMAPPED, 11'($urandom));
        i_cfg_valid <= 1'b0;
        cur_w = (w == 0) ? 1 : (w > sarc_pkg::MAX_WIDTH) ? sarc_pkg::MAX_WIDTH : int'(w);
        cur_h = (h == 0) ? 1 : (h > sarc_pkg::MAX_HEIGHT) ? sarc_pkg::MAX_HEIGHT : int'(h);
    endtask

    task automatic push_pixel(input logic [sarc_pkg::PIX_W-1:0] pix);
        if (!quiet && idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
            i_pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel       <= pix;
        do @(posedge i_clk); while (o_pixel_stall);
    endtask

    task automatic run_frame(input t_fill fill, input bit counted);
        for (int r = 0; r < cur_h; r++) begin
            for (int c = 0; c < cur_w; c++) begin
                push_pixel(pixel_for(fill, r, c));
                if (counted) begin
                    random_fed++;
                    if (random_fed > QUIET_AFTER) quiet = 1'b1;
                end
            end
        end
    endtask

    // drain every owed angle and let the divider go quiet before touching registers
    task automatic settle();
        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (angles_owed != 0);
        repeat (70) @(posedge i_clk);
    endtask

    initial begin
        logic [sarc_pkg::SIZE_W-1:0] w;
        logic [sarc_pkg::SIZE_W-1:0] h;
        logic [sarc_pkg::SIZE_W-1:0] m;
        int shape;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // margin left at its reset value covers the whole small frame
        idle_level = 1;
        write_reg(sarc_pkg::CFG_FRAME_WIDTH, 11'd5);
        write_reg(sarc_pkg::CFG_FRAME_HEIGHT, 11'd4);
        i_cfg_valid <= 1'b0;
        cur_w = 5;
        cur_h = 4;
        run_frame(FILL_SOLID, 1'b0);
        settle();

        configure(11'd4, 11'd4, 11'd0);
        run_frame(FILL_SOLID, 1'b0);
        run_frame(FILL_RANDOM, 1'b0);
        settle();

        // zero sizes behave as one pixel
        configure(11'd0, 11'd0, 11'd0);
        run_frame(FILL_SOLID, 1'b0);
        run_frame(FILL_SOLID, 1'b0);
        settle();

        // one far pixel on one side drives the angle into saturation
        idle_level = 3;
        configure(11'd3, 11'd70, 11'd0);
        run_frame(FILL_LEFT_LOW, 1'b0);
        run_frame(FILL_RIGHT_LOW, 1'b0);
        settle();

        configure(11'd6, 11'd20, 11'd0);
        run_frame(FILL_SKEW_LEFT, 1'b0);
        run_frame(FILL_SKEW_RIGHT, 1'b0);
        settle();

        // margin field truncates to its all-ones value
        configure(11'd9, 11'd9, 11'h7FF);
        run_frame(FILL_SOLID, 1'b0);
        settle();

        while (random_fed < RANDOM_PIXELS) begin
            idle_level = $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                w = $urandom_range(3, 6);
                h = $urandom_range(30, 60);
                m = $urandom_range(0, 2);
            end else if (shape == 1) begin
                w = $urandom_range(0, 1);
                h = $urandom_range(0, 12);
                m = $urandom_range(0, 2047);
            end else if (shape == 2) begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
                m = $urandom_range(0, 2047);
            end else begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 8);
                m = $urandom_range(0, 3);
            end
            configure(w, h, m);
            repeat ($urandom_range(1, 4)) run_frame(pick_fill(), 1'b1);
            settle();
        end

        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (angles_owed != 0);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && angles_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
